// File: rtl/cale_pkg.sv
package cale_pkg;

  localparam int CAPACITY_DEFAULT = 16;
  localparam int DATA_WIDTH_DEFAULT = 32;

  localparam logic [4:0] LIMIT_RESET = 5'd16;

  localparam logic [3:0] REQ_INSERT   = 4'd0;
  localparam logic [3:0] REQ_APPEND   = 4'd1;
  localparam logic [3:0] REQ_REMOVE   = 4'd2;
  localparam logic [3:0] REQ_TO_START = 4'd3;
  localparam logic [3:0] REQ_TO_END   = 4'd4;
  localparam logic [3:0] REQ_PREV     = 4'd5;
  localparam logic [3:0] REQ_NEXT     = 4'd6;
  localparam logic [3:0] REQ_SET_LOC  = 4'd7;
  localparam logic [3:0] REQ_CLEAR    = 4'd8;
  localparam logic [3:0] REQ_READ     = 4'd9;

  localparam logic [1:0] STAT_OK          = 2'd0;
  localparam logic [1:0] STAT_FULL        = 2'd1;
  localparam logic [1:0] STAT_EMPTY       = 2'd2;
  localparam logic [1:0] STAT_LOC_IGNORED = 2'd3;

  typedef enum logic [1:0] {
    CELL_HOLD       = 2'd0,
    CELL_LOAD       = 2'd1,
    CELL_SHIFT_UP   = 2'd2,
    CELL_SHIFT_DOWN = 2'd3
  } cell_op_t;

endpackage

// File: rtl/cale_cell.sv
module cale_cell #(
  parameter int DATA_WIDTH = 32
) (
  input  logic                  clk,
  input  cale_pkg::cell_op_t    op,
  input  logic [DATA_WIDTH-1:0] item,
  input  logic [DATA_WIDTH-1:0] lower_word,
  input  logic [DATA_WIDTH-1:0] upper_word,
  output logic [DATA_WIDTH-1:0] word
);
  import cale_pkg::*;

  always_ff @(posedge clk) begin
    case (op)
      CELL_LOAD:       word <= item;
      CELL_SHIFT_UP:   word <= lower_word;
      CELL_SHIFT_DOWN: word <= upper_word;
      default:         word <= word;
    endcase
  end

endmodule

// File: rtl/cursor_array_list_engine_core.sv
// Bounded ordered list with a cursor, held in a row of cells, one entry per cell.
// Every request returns one result with status, data, entry count and cursor.
// The engine takes one request per clock cycle; its result is registered and
// appears in the cycle after the request is taken. Insert and remove move all
// later entries in that same cycle, since each cell loads from its neighbor.
// A new request is taken while the previous result is being delivered, and
// waits while a result is held back by the downstream side or while reset is high.
module cursor_array_list_engine_core #(
  parameter int CAPACITY   = cale_pkg::CAPACITY_DEFAULT,
  parameter int DATA_WIDTH = cale_pkg::DATA_WIDTH_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_wr_en,
  input  logic [4:0]         cfg_wr_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         req_type,
  input  logic signed [31:0] item_value,
  input  logic [3:0]         target_location,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [31:0] data_out,
  output logic [4:0]         entry_count,
  output logic [3:0]         cursor_pos
);
  import cale_pkg::*;

  localparam int CW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int NW = $clog2(CAPACITY + 1);
  localparam int LW = (NW > 5) ? NW : 5;
  localparam int TW = (NW > 4) ? NW : 4;

  logic [4:0]            capacity_limit;
  logic [NW-1:0]         count;
  logic [NW-1:0]         count_next;
  logic [CW-1:0]         cursor;
  logic [CW-1:0]         cursor_next;
  logic [DATA_WIDTH-1:0] words [CAPACITY];
  cell_op_t              ops [CAPACITY];
  logic [DATA_WIDTH-1:0] item;
  logic [LW-1:0]         active_limit;
  logic                  full;
  logic                  accept;
  logic [1:0]            status_next;
  logic [CW-1:0]         rd_idx;
  logic [DATA_WIDTH-1:0] rd_word;
  logic [DATA_WIDTH-1:0] sel_word;
  logic                  use_item;
  logic                  zero_data;

  assign accept   = in_valid && in_ready;
  assign in_ready = !rst && (!out_valid || out_ready);
  assign item     = DATA_WIDTH'($unsigned(item_value));

  always_comb begin
    if (capacity_limit == 5'd0) begin
      active_limit = LW'(1);
    end else if (LW'(capacity_limit) > LW'(CAPACITY)) begin
      active_limit = LW'(CAPACITY);
    end else begin
      active_limit = LW'(capacity_limit);
    end
  end

  assign full = LW'(count) >= active_limit;

  always_comb begin
    count_next  = count;
    cursor_next = cursor;
    status_next = STAT_OK;
    rd_idx      = cursor;
    use_item    = 1'b0;
    case (req_type)
      REQ_INSERT: begin
        if (full) begin
          status_next = STAT_FULL;
        end else begin
          count_next = count + NW'(1);
          use_item   = 1'b1;
        end
      end
      REQ_APPEND: begin
        if (full) begin
          status_next = STAT_FULL;
        end else begin
          count_next = count + NW'(1);
          use_item   = (count == NW'(0));
        end
      end
      REQ_REMOVE: begin
        if (count == NW'(0)) begin
          status_next = STAT_EMPTY;
        end else begin
          count_next = count - NW'(1);
          if (NW'(cursor) == count - NW'(1) && count > NW'(1)) begin
            cursor_next = cursor - CW'(1);
          end
        end
      end
      REQ_TO_START: begin
        cursor_next = '0;
      end
      REQ_TO_END: begin
        cursor_next = (count == NW'(0)) ? '0 : CW'(count - NW'(1));
      end
      REQ_PREV: begin
        if (cursor != '0) begin
          cursor_next = cursor - CW'(1);
        end
      end
      REQ_NEXT: begin
        if (NW'(cursor) + NW'(1) < count) begin
          cursor_next = cursor + CW'(1);
        end
      end
      REQ_SET_LOC: begin
        if (TW'(target_location) < TW'(count)) begin
          cursor_next = CW'(target_location);
        end else begin
          status_next = STAT_LOC_IGNORED;
        end
      end
      REQ_CLEAR: begin
        count_next  = '0;
        cursor_next = '0;
      end
      default: begin
      end
    endcase
    if (req_type != REQ_REMOVE) begin
      rd_idx = cursor_next;
    end
  end

  always_comb begin
    if (int'(rd_idx) < CAPACITY) begin
      rd_word = words[rd_idx];
    end else begin
      rd_word = '0;
    end
  end

  assign zero_data = (count_next == NW'(0)) &&
                     !(req_type == REQ_REMOVE && count != NW'(0));

  always_comb begin
    if (zero_data) begin
      sel_word = '0;
    end else if (use_item) begin
      sel_word = item;
    end else begin
      sel_word = rd_word;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] lower_word;
    logic [DATA_WIDTH-1:0] upper_word;

    if (i == 0) begin : g_first
      assign lower_word = '0;
    end else begin : g_lower
      assign lower_word = words[i-1];
    end

    if (i == CAPACITY - 1) begin : g_last
      assign upper_word = words[i];
    end else begin : g_upper
      assign upper_word = words[i+1];
    end

    always_comb begin
      ops[i] = CELL_HOLD;
      if (accept) begin
        case (req_type)
          REQ_INSERT: begin
            if (!full) begin
              if (NW'(i) == NW'(cursor)) begin
                ops[i] = CELL_LOAD;
              end else if (NW'(i) > NW'(cursor) && NW'(i) <= count) begin
                ops[i] = CELL_SHIFT_UP;
              end
            end
          end
          REQ_APPEND: begin
            if (!full && NW'(i) == count) begin
              ops[i] = CELL_LOAD;
            end
          end
          REQ_REMOVE: begin
            if (NW'(i) >= NW'(cursor) && NW'(i) + NW'(1) < count) begin
              ops[i] = CELL_SHIFT_DOWN;
            end
          end
          default: begin
          end
        endcase
      end
    end

    cale_cell #(
      .DATA_WIDTH(DATA_WIDTH)
    ) u_cell (
      .clk       (clk),
      .op        (ops[i]),
      .item      (item),
      .lower_word(lower_word),
      .upper_word(upper_word),
      .word      (words[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      capacity_limit <= LIMIT_RESET;
      count          <= '0;
      cursor         <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        capacity_limit <= cfg_wr_data;
      end
      if (accept) begin
        count     <= count_next;
        cursor    <= cursor_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status      <= status_next;
      data_out    <= 32'($signed(sel_word));
      entry_count <= 5'(count_next);
      cursor_pos  <= 4'(cursor_next);
    end
  end

endmodule
